// ===== rtl/fourier_phase_ramp_shift_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the Fourier phase ramp shifter
// Shorthand for clocked implication checks with the usual reset disable.
// ----------------------------------------------------------------------------
`ifndef FOURIER_PHASE_RAMP_SHIFT_DEFINES_SVH
`define FOURIER_PHASE_RAMP_SHIFT_DEFINES_SVH

// Same-cycle implication.
`define FRP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("frp check failed (same cycle)");

// Next-cycle implication.
`define FRP_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("frp check failed (next cycle)");

`endif

// ===== rtl/frp_pkg.sv =====
// ----------------------------------------------------------------------------
// Fourier phase ramp shifter package
// Widths, register indexes, the CORDIC word and the arctangent table.
// ----------------------------------------------------------------------------
package frp_pkg;

    localparam int DATA_W         = 24;
    localparam int PHASE_W        = 32;
    localparam int DIM_W          = 12;
    localparam int CFG_INDEX_W    = 4;
    localparam int CFG_DATA_W     = 32;
    localparam int CORDIC_ITERS   = 24;
    localparam int XW             = 57;
    localparam int ZW             = 32;
    localparam int MAX_WIDTH_DEF  = 2048;
    localparam int MAX_HEIGHT_DEF = 2048;

    // Inverse CORDIC gain in Q30.
    localparam logic signed [30:0] GAIN_Q30 = 31'sd652032874;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_ROW_LENGTH   = 4'd0,
        REG_ROW_COUNT    = 4'd1,
        REG_PHASE_STEP_X = 4'd2,
        REG_PHASE_STEP_Y = 4'd3
    } cfg_reg_t;

    typedef struct packed {
        logic                     bypass;
        logic signed [DATA_W-1:0] c;
        logic signed [DATA_W-1:0] d;
        logic signed [XW-1:0]     x;
        logic signed [XW-1:0]     y;
        logic signed [ZW-1:0]     z;
    } cordic_word_t;

    // Arctangent of 2^-i in 2^-32 turn units.
    function automatic logic signed [ZW-1:0] atan_turn(input int i);
        logic signed [ZW-1:0] a;
        case (i)
            0:       a = 32'sd536870912;
            1:       a = 32'sd316933406;
            2:       a = 32'sd167458907;
            3:       a = 32'sd85004756;
            4:       a = 32'sd42667331;
            5:       a = 32'sd21354465;
            6:       a = 32'sd10679838;
            7:       a = 32'sd5340245;
            8:       a = 32'sd2670163;
            9:       a = 32'sd1335087;
            10:      a = 32'sd667544;
            11:      a = 32'sd333772;
            12:      a = 32'sd166886;
            13:      a = 32'sd83443;
            14:      a = 32'sd41722;
            15:      a = 32'sd20861;
            16:      a = 32'sd10430;
            17:      a = 32'sd5215;
            18:      a = 32'sd2608;
            19:      a = 32'sd1304;
            20:      a = 32'sd652;
            21:      a = 32'sd326;
            22:      a = 32'sd163;
            23:      a = 32'sd81;
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

// ===== rtl/frp_if.sv =====
// ----------------------------------------------------------------------------
// Fourier phase ramp shifter channels
// Sample input, result output and configuration write channels.
// ----------------------------------------------------------------------------
interface frp_in_if;
    import frp_pkg::*;
    logic                     valid;
    logic                     ready;
    logic                     frame_start;
    logic signed [DATA_W-1:0] sample_re;
    logic signed [DATA_W-1:0] sample_im;

    modport source (output valid, frame_start, sample_re, sample_im, input ready);
    modport sink   (input valid, frame_start, sample_re, sample_im, output ready);
endinterface

interface frp_out_if;
    import frp_pkg::*;
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] shifted_re;
    logic signed [DATA_W-1:0] shifted_im;

    modport source (output valid, shifted_re, shifted_im, input ready);
    modport sink   (input valid, shifted_re, shifted_im, output ready);
endinterface

interface frp_cfg_if;
    import frp_pkg::*;
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/frp_front.sv =====
// ----------------------------------------------------------------------------
// Fourier phase ramp shifter front end
// Registers, coordinate counters, phase sum, quadrant pre-rotation and gain.
// ----------------------------------------------------------------------------
`include "fourier_phase_ramp_shift_defines.svh"

module frp_front #(
    parameter int MAX_WIDTH  = frp_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = frp_pkg::MAX_HEIGHT_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    frp_cfg_if.sink              cfg,
    frp_in_if.sink               sample_in,
    output frp_pkg::cordic_word_t word,
    output logic                 word_valid,
    input  logic                 word_ready
);
    import frp_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int LW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int YW = HW + 1;
    localparam int PW = DATA_W + 1;

    typedef enum logic [1:0] {
        QUAD_0 = 2'd0,
        QUAD_1 = 2'd1,
        QUAD_2 = 2'd2,
        QUAD_3 = 2'd3
    } quadrant_t;

    logic [DIM_W-1:0]   row_length_reg;
    logic [DIM_W-1:0]   row_count_reg;
    logic [PHASE_W-1:0] step_x_reg;
    logic [PHASE_W-1:0] step_y_reg;

    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;

    logic [LW-1:0]       len;
    logic [HW-1:0]       hgt;
    logic [CW-1:0]       col_base, col_eff;
    logic [RW-1:0]       row_base, row_eff;
    logic [PHASE_W-1:0]  col_inc, row_inc;
    logic signed [YW-1:0] yv;
    logic                accept;

    logic                     s0_valid_reg, s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic                     s0_ready, s1_ready, s2_ready, s3_ready;
    logic                     s0_bypass_reg, s1_bypass_reg, s2_bypass_reg;
    logic signed [DATA_W-1:0] s0_c_reg, s0_d_reg, s1_c_reg, s1_d_reg, s2_c_reg, s2_d_reg;
    logic [CW-1:0]            s0_col_reg;
    logic signed [YW-1:0]     s0_yv_reg;
    logic [PHASE_W-1:0]       s1_prod_x_reg, s1_prod_y_reg;
    logic signed [PW-1:0]     s2_px_reg, s2_py_reg;
    logic signed [ZW-1:0]     s2_z_reg;
    cordic_word_t             s3_word_reg;

    logic [PHASE_W-1:0]   ang, ang_res;
    quadrant_t            quad;
    logic signed [PW-1:0] c_ext, d_ext, px, py;
    logic signed [PW+30:0] gx, gy;

    function automatic logic [1:0] ang_quadrant(input logic [PHASE_W-1:0] a);
        logic [PHASE_W-1:0] t;
        t = a + 32'h2000_0000;
        return t[PHASE_W-1:PHASE_W-2];
    endfunction

    // Configuration writes
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_length_reg <= DIM_W'(1025);
            row_count_reg  <= DIM_W'(2048);
            step_x_reg     <= '0;
            step_y_reg     <= '0;
        end
        else if (cfg.valid)
        begin
            case (cfg_reg_t'(cfg.index))
                REG_ROW_LENGTH:   row_length_reg <= cfg.data[DIM_W-1:0];
                REG_ROW_COUNT:    row_count_reg  <= cfg.data[DIM_W-1:0];
                REG_PHASE_STEP_X: step_x_reg     <= cfg.data[PHASE_W-1:0];
                REG_PHASE_STEP_Y: step_y_reg     <= cfg.data[PHASE_W-1:0];
                default:          ;
            endcase
        end
    end

    // Dimensions clamped to the supported range
    always_comb
    begin
        if (row_length_reg == '0)
            len = LW'(1);
        else if (32'(row_length_reg) > 32'(MAX_WIDTH))
            len = LW'(MAX_WIDTH);
        else
            len = LW'(row_length_reg);

        if (row_count_reg == '0)
            hgt = HW'(1);
        else if (32'(row_count_reg) > 32'(MAX_HEIGHT))
            hgt = HW'(MAX_HEIGHT);
        else
            hgt = HW'(row_count_reg);
    end

    // Coordinates of the current word and the counters for the next one
    always_comb
    begin
        col_base = sample_in.frame_start ? '0 : col_reg;
        row_base = sample_in.frame_start ? '0 : row_reg;
        col_eff  = (32'(col_base) >= 32'(len)) ? '0 : col_base;
        row_eff  = (32'(row_base) >= 32'(hgt)) ? '0 : row_base;
        col_inc  = 32'(col_eff) + 32'd1;
        row_inc  = 32'(row_eff) + 32'd1;

        if (col_inc >= 32'(len))
        begin
            col_next = '0;
            row_next = (row_inc >= 32'(hgt)) ? '0 : row_inc[RW-1:0];
        end
        else
        begin
            col_next = col_inc[CW-1:0];
            row_next = row_eff;
        end

        // Rows whose index reaches the row length map to negative frequencies.
        if (32'(row_eff) < 32'(len))
            yv = $signed(YW'(row_eff));
        else
            yv = $signed(YW'(row_eff)) - $signed(YW'(hgt));
    end

    assign accept          = sample_in.valid && s0_ready;
    assign sample_in.ready = s0_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (accept)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // Stage handshakes: a stage loads when it is empty or its word moves on.
    assign s3_ready = !s3_valid_reg || word_ready;
    assign s2_ready = !s2_valid_reg || s3_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign s0_ready = !s0_valid_reg || s1_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (s0_ready)
                s0_valid_reg <= sample_in.valid;
            if (s1_ready)
                s1_valid_reg <= s0_valid_reg;
            if (s2_ready)
                s2_valid_reg <= s1_valid_reg;
            if (s3_ready)
                s3_valid_reg <= s2_valid_reg;
        end
    end

    // Phase sum, quadrant, residual angle, quadrant pre-rotation and gain products
    always_comb
    begin
        ang     = PHASE_W'(0) - (s1_prod_x_reg + s1_prod_y_reg);
        quad    = quadrant_t'(ang_quadrant(ang));
        ang_res = ang - {ang_quadrant(ang), 30'b0};
        c_ext   = PW'(s1_c_reg);
        d_ext   = PW'(s1_d_reg);
        case (quad)
            QUAD_0:
            begin
                px = c_ext;
                py = d_ext;
            end
            QUAD_1:
            begin
                px = -d_ext;
                py = c_ext;
            end
            QUAD_2:
            begin
                px = -c_ext;
                py = -d_ext;
            end
            QUAD_3:
            begin
                px = d_ext;
                py = -c_ext;
            end
            default:
            begin
                px = c_ext;
                py = d_ext;
            end
        endcase
        gx = s2_px_reg * GAIN_Q30;
        gy = s2_py_reg * GAIN_Q30;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s0_c_reg      <= sample_in.sample_re;
            s0_d_reg      <= sample_in.sample_im;
            s0_col_reg    <= col_eff;
            s0_yv_reg     <= yv;
            s0_bypass_reg <= (step_x_reg == '0) && (step_y_reg == '0);
        end
        if (s1_ready && s0_valid_reg)
        begin
            s1_prod_x_reg <= PHASE_W'(PHASE_W'(s0_col_reg) * step_x_reg);
            s1_prod_y_reg <= PHASE_W'(PHASE_W'(s0_yv_reg) * step_y_reg);
            s1_c_reg      <= s0_c_reg;
            s1_d_reg      <= s0_d_reg;
            s1_bypass_reg <= s0_bypass_reg;
        end
        if (s2_ready && s1_valid_reg)
        begin
            s2_px_reg     <= px;
            s2_py_reg     <= py;
            s2_z_reg      <= $signed(ang_res);
            s2_c_reg      <= s1_c_reg;
            s2_d_reg      <= s1_d_reg;
            s2_bypass_reg <= s1_bypass_reg;
        end
        if (s3_ready && s2_valid_reg)
        begin
            s3_word_reg.x      <= XW'(gx);
            s3_word_reg.y      <= XW'(gy);
            s3_word_reg.z      <= s2_z_reg;
            s3_word_reg.c      <= s2_c_reg;
            s3_word_reg.d      <= s2_d_reg;
            s3_word_reg.bypass <= s2_bypass_reg;
        end
    end

    assign word       = s3_word_reg;
    assign word_valid = s3_valid_reg;

    `FRP_ASSERT_NXT(a_accept_loads_s0, clk, rst_n, accept, s0_valid_reg)
    `FRP_ASSERT_NXT(a_frame_start_clears, clk, rst_n, accept && sample_in.frame_start,
        (col_reg == '0 || col_reg == CW'(1)) && (row_reg == '0 || row_reg == RW'(1)))
    `FRP_ASSERT_NXT(a_s1_holds_when_blocked, clk, rst_n, s1_valid_reg && !s2_ready,
        s1_valid_reg && $stable(s1_prod_x_reg) && $stable(s1_prod_y_reg))

endmodule

// ===== rtl/frp_cordic_cell.sv =====
// ----------------------------------------------------------------------------
// Fourier phase ramp shifter CORDIC cell
// One rotation iteration with its own word register and handshake.
// ----------------------------------------------------------------------------
module frp_cordic_cell #(
    parameter int STAGE = 0
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  frp_pkg::cordic_word_t word_in,
    input  logic                  in_valid,
    output logic                  in_ready,
    output frp_pkg::cordic_word_t word_out,
    output logic                  out_valid,
    input  logic                  out_ready
);
    import frp_pkg::*;

    logic                 valid_reg;
    cordic_word_t         word_reg, word_next;
    logic signed [XW-1:0] dx, dy;

    assign in_ready = !valid_reg || out_ready;

    // Arithmetic shifts round towards minus infinity, as the rotation needs.
    always_comb
    begin
        dx        = $signed(word_in.y) >>> STAGE;
        dy        = $signed(word_in.x) >>> STAGE;
        word_next = word_in;
        if (!word_in.z[ZW-1])
        begin
            word_next.x = $signed(word_in.x) - dx;
            word_next.y = $signed(word_in.y) + dy;
            word_next.z = $signed(word_in.z) - atan_turn(STAGE);
        end
        else
        begin
            word_next.x = $signed(word_in.x) + dx;
            word_next.y = $signed(word_in.y) - dy;
            word_next.z = $signed(word_in.z) + atan_turn(STAGE);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            word_reg <= word_next;
    end

    assign word_out  = word_reg;
    assign out_valid = valid_reg;

endmodule

// ===== rtl/frp_round.sv =====
// ----------------------------------------------------------------------------
// Fourier phase ramp shifter output stage
// Rounds and saturates the rotated word and holds it for the sink.
// ----------------------------------------------------------------------------
module frp_round (
    input  logic                  clk,
    input  logic                  rst_n,
    input  frp_pkg::cordic_word_t word_in,
    input  logic                  in_valid,
    output logic                  in_ready,
    frp_out_if.source             result_out
);
    import frp_pkg::*;

    localparam logic signed [XW-1:0] HALF   = XW'(64'sd1 <<< 29);
    localparam logic signed [XW-1:0] SAT_HI = XW'((64'sd1 <<< (DATA_W - 1)) - 64'sd1);
    localparam logic signed [XW-1:0] SAT_LO = XW'(-(64'sd1 <<< (DATA_W - 1)));

    logic                     valid_reg;
    logic signed [DATA_W-1:0] re_reg, im_reg, re_next, im_next;

    function automatic logic signed [DATA_W-1:0] round_sat(input logic signed [XW-1:0] v);
        logic signed [XW-1:0] r;
        logic signed [DATA_W-1:0] o;
        r = (v + HALF) >>> 30;
        if (r > SAT_HI)
            o = SAT_HI[DATA_W-1:0];
        else if (r < SAT_LO)
            o = SAT_LO[DATA_W-1:0];
        else
            o = r[DATA_W-1:0];
        return o;
    endfunction

    // With both steps zero the sample goes out untouched.
    always_comb
    begin
        if (word_in.bypass)
        begin
            re_next = word_in.c;
            im_next = word_in.d;
        end
        else
        begin
            re_next = round_sat(word_in.x);
            im_next = round_sat(word_in.y);
        end
    end

    assign in_ready = !valid_reg || result_out.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            re_reg <= re_next;
            im_reg <= im_next;
        end
    end

    assign result_out.valid      = valid_reg;
    assign result_out.shifted_re = re_reg;
    assign result_out.shifted_im = im_reg;

endmodule

// ===== rtl/fourier_phase_ramp_shift.sv =====
// ----------------------------------------------------------------------------
// Fourier phase ramp shifter
// Streams half-complex 2D spectrum samples in raster order and rotates each by
// the phase ramp -(x*phase_step_x + y*phase_step_y) turns, which shifts the
// image. One word is accepted per cycle when the sink keeps up; each word
// passes through four front stages (coordinates, step products, quadrant,
// gain), a chain of 24 CORDIC cells and one output register. Every stage
// stalls on its own, so bubbles close up while the sink waits. Configuration
// writes are taken at any time but belong in idle periods; a word flagged
// frame_start restarts the coordinates.
// ----------------------------------------------------------------------------
module fourier_phase_ramp_shift #(
    parameter int MAX_WIDTH  = frp_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = frp_pkg::MAX_HEIGHT_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    frp_cfg_if.sink   cfg,
    frp_in_if.sink    sample_in,
    frp_out_if.source result_out
);
    import frp_pkg::*;

    cordic_word_t words  [0:CORDIC_ITERS];
    logic         valids [0:CORDIC_ITERS];
    logic         readys [0:CORDIC_ITERS];

    frp_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .sample_in  (sample_in),
        .word       (words[0]),
        .word_valid (valids[0]),
        .word_ready (readys[0])
    );

    for (genvar g = 0; g < CORDIC_ITERS; g++)
    begin : g_cell
        frp_cordic_cell #(
            .STAGE (g)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .word_in   (words[g]),
            .in_valid  (valids[g]),
            .in_ready  (readys[g]),
            .word_out  (words[g+1]),
            .out_valid (valids[g+1]),
            .out_ready (readys[g+1])
        );
    end

    frp_round u_round (
        .clk        (clk),
        .rst_n      (rst_n),
        .word_in    (words[CORDIC_ITERS]),
        .in_valid   (valids[CORDIC_ITERS]),
        .in_ready   (readys[CORDIC_ITERS]),
        .result_out (result_out)
    );

endmodule
